### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ACPE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define ACPE_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### rtl/acpe_pkg.sv
package acpe_pkg;

    localparam logic [5:0]  POLL_DONE   = 6'd33;
    localparam logic [10:0] WINDOW_LOW  = 11'd130;
    localparam logic [10:0] WINDOW_HIGH = 11'd256;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_FRAME = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [8:0]  line_number;
        logic [10:0] line_clock;
        logic [8:0]  display_lines;
        logic [1:0]  port_one_bits;
        logic [1:0]  port_two_bits;
    } t_item;

    typedef struct packed {
        logic        latch_level;
        logic        sample_strobe;
        logic [15:0] pad_one;
        logic [15:0] pad_two;
        logic [15:0] pad_three;
        logic [15:0] pad_four;
        logic        poll_busy;
    } t_result;

endpackage

### rtl/acpe_if.sv
interface acpe_item_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [8:0]  line_number;
    logic [10:0] line_clock;
    logic [8:0]  display_lines;
    logic [1:0]  port_one_bits;
    logic [1:0]  port_two_bits;

    modport source (
        output valid, opcode, line_number, line_clock, display_lines,
               port_one_bits, port_two_bits,
        input  ready
    );
    modport sink (
        input  valid, opcode, line_number, line_clock, display_lines,
               port_one_bits, port_two_bits,
        output ready
    );
endinterface

interface acpe_result_if;
    logic        valid;
    logic        ready;
    logic        latch_level;
    logic        sample_strobe;
    logic [15:0] pad_one;
    logic [15:0] pad_two;
    logic [15:0] pad_three;
    logic [15:0] pad_four;
    logic        poll_busy;

    modport source (
        output valid, latch_level, sample_strobe, pad_one, pad_two, pad_three,
               pad_four, poll_busy,
        input  ready
    );
    modport sink (
        input  valid, latch_level, sample_strobe, pad_one, pad_two, pad_three,
               pad_four, poll_busy,
        output ready
    );
endinterface

interface acpe_cfg_if;
    logic valid;
    logic ready;
    logic auto_poll_enable;

    modport source (
        output valid, auto_poll_enable,
        input  ready
    );
    modport sink (
        input  valid, auto_poll_enable,
        output ready
    );
endinterface

### rtl/auto_controller_poll_engine_core.sv
// each item goes through the input register and then the result register
// throughput: one item per cycle while the result side is not stalled
// input and result registers keep both sides moving under backpressure
// synchronous active-low reset: poll step inactive (33), latch and pads zero,
// auto poll disabled, both pipeline stages empty
`include "assert_macros.svh"

module auto_controller_poll_engine_core (
    input logic           i_clk,
    input logic           i_rst_n,
    acpe_item_if.sink     i_item,
    acpe_result_if.source o_result,
    acpe_cfg_if.sink      i_cfg
);
    import acpe_pkg::*;

    logic    r_enable;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    t_result n_out;
    logic    advance;
    logic    in_ready;

    assign advance  = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_item.ready = in_ready;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg.valid) begin
            r_enable <= i_cfg.auto_poll_enable;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_item.valid) begin
            r_in.opcode        <= t_opcode'(i_item.opcode);
            r_in.line_number   <= i_item.line_number;
            r_in.line_clock    <= i_item.line_clock;
            r_in.display_lines <= i_item.display_lines;
            r_in.port_one_bits <= i_item.port_one_bits;
            r_in.port_two_bits <= i_item.port_two_bits;
        end
    end

    acpe_poll_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_enable  (r_enable),
        .i_item    (r_in),
        .o_result  (n_out)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.latch_level   = r_out.latch_level;
    assign o_result.sample_strobe = r_out.sample_strobe;
    assign o_result.pad_one       = r_out.pad_one;
    assign o_result.pad_two       = r_out.pad_two;
    assign o_result.pad_three     = r_out.pad_three;
    assign o_result.pad_four      = r_out.pad_four;
    assign o_result.poll_busy     = r_out.poll_busy;

    `ACPE_ASSERT(a_frame_ends_poll, i_clk, i_rst_n,
        advance && (r_in.opcode == OP_FRAME) |=> !o_result.poll_busy,
        "frame start left poll busy")
    `ACPE_ASSERT(a_strobe_latch_low, i_clk, i_rst_n,
        o_result.valid && o_result.sample_strobe |-> !o_result.latch_level,
        "sample with latch high")
    `ACPE_ASSERT(a_no_advance_when_stalled, i_clk, i_rst_n,
        r_out_valid && !o_result.ready |-> !advance,
        "result overwritten while stalled")
    `ACPE_ASSERT_ALWAYS(a_reset_empties, i_clk,
        !i_rst_n |=> !r_in_valid && !r_out_valid,
        "pipeline not empty after reset")

endmodule

### rtl/acpe_poll_core.sv
module acpe_poll_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_enable,
    input  acpe_pkg::t_item  i_item,
    output acpe_pkg::t_result o_result
);
    import acpe_pkg::*;

    logic [5:0]  r_step;
    logic        r_latch;
    logic [15:0] r_pad [4];

    logic [5:0]  n_step;
    logic        n_latch;
    logic [15:0] n_pad [4];
    logic        strobe;
    logic        in_window;

    assign in_window = (i_item.line_number == i_item.display_lines)
                    && (i_item.line_clock >= WINDOW_LOW)
                    && (i_item.line_clock <= WINDOW_HIGH);

    always_comb begin
        n_step  = r_step;
        n_latch = r_latch;
        n_pad   = r_pad;
        strobe  = 1'b0;
        if (i_item.opcode == OP_FRAME) begin
            n_step = POLL_DONE;
        end else if (i_enable) begin
            if (in_window) begin
                n_step = '0;
            end
            if (n_step < POLL_DONE) begin
                if (n_step == 6'd0) begin
                    n_latch = 1'b1;
                end
                if (n_step == 6'd1) begin
                    n_latch = 1'b0;
                    n_pad   = '{default: '0};
                end
                if (n_step >= 6'd2 && !n_step[0]) begin
                    n_pad[0] = {n_pad[0][14:0], i_item.port_one_bits[0]};
                    n_pad[1] = {n_pad[1][14:0], i_item.port_two_bits[0]};
                    n_pad[2] = {n_pad[2][14:0], i_item.port_one_bits[1]};
                    n_pad[3] = {n_pad[3][14:0], i_item.port_two_bits[1]};
                    strobe   = 1'b1;
                end
                n_step = n_step + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= POLL_DONE;
            r_latch <= 1'b0;
            r_pad   <= '{default: '0};
        end else if (i_advance) begin
            r_step  <= n_step;
            r_latch <= n_latch;
            r_pad   <= n_pad;
        end
    end

    always_comb begin
        o_result.latch_level   = n_latch;
        o_result.sample_strobe = strobe;
        o_result.pad_one       = n_pad[0];
        o_result.pad_two       = n_pad[1];
        o_result.pad_three     = n_pad[2];
        o_result.pad_four      = n_pad[3];
        o_result.poll_busy     = (n_step < POLL_DONE);
    end

endmodule
